// ===== sv/crfo_pkg.sv =====
package crfo_pkg;

   // geometry widths
   localparam int COORD_WIDTH  = 12;
   localparam int RADIUS_WIDTH = 10;
   localparam int OUT_W        = COORD_WIDTH + 1;
   localparam int COLOR_W      = 32;
   localparam int ALPHA_LSB    = 24;
   localparam int ROW_W        = RADIUS_WIDTH + 1;
   localparam int OCTX_W       = RADIUS_WIDTH + 1;
   localparam int OCTY_W       = RADIUS_WIDTH + 2;
   localparam int DEC_W        = RADIUS_WIDTH + 6;
   localparam int SQ_W         = 2 * RADIUS_WIDTH;
   localparam int CNT_W        = $clog2(RADIUS_WIDTH + 1);
   localparam int SUM_W        =
      ((COORD_WIDTH > RADIUS_WIDTH + 2) ? COORD_WIDTH : RADIUS_WIDTH + 2) + 1;

   // stream and register port widths
   localparam int KIND_W      = 2;
   localparam int OCT_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = ((3 * OUT_W + COLOR_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = KIND_W + 1;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [OCT_W-1:0]     oct_type;

   localparam kind_type KIND_SPAN   = 2'd0;
   localparam kind_type KIND_PIXEL  = 2'd1;
   localparam kind_type KIND_FINISH = 2'd2;

   localparam csr_idx_type CSR_CENTER_X      = 3'd0;
   localparam csr_idx_type CSR_CENTER_Y      = 3'd1;
   localparam csr_idx_type CSR_RADIUS        = 3'd2;
   localparam csr_idx_type CSR_OUTLINE_COLOR = 3'd3;
   localparam csr_idx_type CSR_FILL_COLOR    = 3'd4;

   localparam oct_type OCT_FIRST = '0;
   localparam oct_type OCT_LAST  = '1;

   typedef struct packed {
      logic    init_fill;
      logic    init_outline;
      logic    square;
      logic    root_load;
      logic    row_inc;
      logic    advance;
      logic    emit_span;
      logic    emit_pixel;
      logic    emit_finish;
      oct_type octant;
   } crfo_cmd_type;

   typedef struct packed {
      logic fill_on;
      logic fill_last;
      logic y_ge_x;
      logic root_done;
      logic out_free;
   } crfo_status_type;

endpackage

// ===== sv/crfo_isqrt.sv =====
module crfo_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [crfo_pkg::SQ_W-1:0]          n_in,
   output logic                               done,
   output logic [crfo_pkg::RADIUS_WIDTH-1:0]  root
);
   import crfo_pkg::*;

   logic [SQ_W-1:0]  n_ff, n_in_nx;
   logic [SQ_W-1:0]  res_ff, res_in;
   logic [SQ_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W:0]    trial;

   // one root bit per cycle, two radicand bits consumed, restoring compare and subtract
   always_comb begin
      n_in_nx = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         n_in_nx = n_in;
         res_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         cnt_in  = CNT_W'(RADIUS_WIDTH);
      end else if (cnt_ff != '0) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in_nx = n_ff - trial[SQ_W-1:0];
            res_in  = (res_ff >> 1) + bit_ff;
         end else begin
            res_in  = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      n_ff   <= n_in_nx;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = (cnt_ff == '0);
   assign root = res_ff[RADIUS_WIDTH-1:0];

endmodule

// ===== sv/crfo_datapath.sv =====
module crfo_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  crfo_pkg::csr_idx_type              csr_index,
   input  logic [crfo_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  crfo_pkg::crfo_cmd_type             cmd,
   output crfo_pkg::crfo_status_type          status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [crfo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [crfo_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast
);
   import crfo_pkg::*;

   // configuration
   logic [COORD_WIDTH-1:0]  center_x_ff, center_x_in;
   logic [COORD_WIDTH-1:0]  center_y_ff, center_y_in;
   logic [RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic [COLOR_W-1:0]      outline_color_ff, outline_color_in;
   logic [COLOR_W-1:0]      fill_color_ff, fill_color_in;

   // drawing state
   logic [ROW_W-1:0]  row_offset_ff, row_offset_in;
   logic [OCTX_W-1:0] octant_x_ff, octant_x_in;
   logic [OCTY_W-1:0] octant_y_ff, octant_y_in;
   logic [DEC_W-1:0]  decision_ff, decision_in;
   logic [SQ_W-1:0]   r2_ff, r2_in;
   logic [SQ_W-1:0]   y2_ff, y2_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [2*ROW_W-1:0]      ysq_full;
   logic [SQ_W:0]           rem_full;
   logic [SQ_W-1:0]         sqrt_n;
   logic [RADIUS_WIDTH-1:0] root;
   logic                    root_done;
   logic [OCTX_W-1:0]       x_new;
   logic [OCTY_W-1:0]       y_new;
   logic [DEC_W-1:0]        diff;
   logic [SUM_W-1:0]        cx_ext, cy_ext, col_off, row_off, col_val, row_val;
   logic [SUM_W-1:0]        span_xs, span_xe, span_row;

   crfo_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_load),
      .n_in  (sqrt_n),
      .done  (root_done),
      .root  (root)
   );

   always_comb begin
      ysq_full = $signed(row_offset_ff) * $signed(row_offset_ff);
      rem_full = {1'b0, r2_ff} - {1'b0, y2_ff};
      sqrt_n   = rem_full[SQ_W] ? '0 : rem_full[SQ_W-1:0];

      cx_ext   = SUM_W'($signed(center_x_ff));
      cy_ext   = SUM_W'($signed(center_y_ff));
      span_xs  = cx_ext - SUM_W'(root);
      span_xe  = cx_ext + SUM_W'(root);
      span_row = cy_ext + SUM_W'($signed(row_offset_ff));

      // octant bit 2 swaps x and y, bit 0 mirrors the column, bit 1 the row
      col_off = cmd.octant[2] ? SUM_W'($signed(octant_y_ff)) : SUM_W'(octant_x_ff);
      row_off = cmd.octant[2] ? SUM_W'(octant_x_ff) : SUM_W'($signed(octant_y_ff));
      col_val = cmd.octant[0] ? cx_ext - col_off : cx_ext + col_off;
      row_val = cmd.octant[1] ? cy_ext - row_off : cy_ext + row_off;

      x_new = octant_x_ff + OCTX_W'(1);
      y_new = octant_y_ff - OCTY_W'(1);
      diff  = DEC_W'(x_new) - DEC_W'($signed(y_new));
   end

   always_comb begin
      center_x_in      = center_x_ff;
      center_y_in      = center_y_ff;
      radius_in        = radius_ff;
      outline_color_in = outline_color_ff;
      fill_color_in    = fill_color_ff;
      row_offset_in    = row_offset_ff;
      octant_x_in      = octant_x_ff;
      octant_y_in      = octant_y_ff;
      decision_in      = decision_ff;
      r2_in            = r2_ff;
      y2_in            = y2_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_user_in      = rsp_user_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:      center_x_in      = csr_wdata[COORD_WIDTH-1:0];
            CSR_CENTER_Y:      center_y_in      = csr_wdata[COORD_WIDTH-1:0];
            CSR_RADIUS:        radius_in        = csr_wdata[RADIUS_WIDTH-1:0];
            CSR_OUTLINE_COLOR: outline_color_in = csr_wdata[COLOR_W-1:0];
            CSR_FILL_COLOR:    fill_color_in    = csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.init_fill) begin
         row_offset_in = ROW_W'(0) - ROW_W'(radius_ff);
      end
      if (cmd.row_inc) begin
         row_offset_in = row_offset_ff + ROW_W'(1);
      end
      if (cmd.init_outline) begin
         octant_x_in = '0;
         octant_y_in = OCTY_W'(radius_ff);
         decision_in = DEC_W'(3) - DEC_W'({radius_ff, 1'b0});
      end
      if (cmd.advance) begin
         octant_x_in = x_new;
         if (!decision_ff[DEC_W-1] && decision_ff != '0) begin
            octant_y_in = y_new;
            decision_in = decision_ff + (diff << 2) + DEC_W'(10);
         end else begin
            decision_in = decision_ff + (DEC_W'(x_new) << 2) + DEC_W'(6);
         end
      end
      if (cmd.square) begin
         r2_in = SQ_W'(radius_ff) * SQ_W'(radius_ff);
         y2_in = ysq_full[SQ_W-1:0];
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_span) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({fill_color_ff, span_row[OUT_W-1:0],
                                     span_xe[OUT_W-1:0], span_xs[OUT_W-1:0]});
         rsp_user_in  = {1'b0, KIND_SPAN};
         rsp_last_in  = 1'b1;
      end
      if (cmd.emit_pixel) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({outline_color_ff, row_val[OUT_W-1:0],
                                     col_val[OUT_W-1:0], col_val[OUT_W-1:0]});
         rsp_user_in  = {1'b0, KIND_PIXEL};
         rsp_last_in  = (cmd.octant == OCT_LAST);
      end
      if (cmd.emit_finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_user_in  = {1'b1, KIND_FINISH};
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         radius_ff        <= '0;
         outline_color_ff <= '0;
         fill_color_ff    <= '0;
         row_offset_ff    <= '0;
         octant_x_ff      <= '0;
         octant_y_ff      <= '0;
         decision_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         center_x_ff      <= center_x_in;
         center_y_ff      <= center_y_in;
         radius_ff        <= radius_in;
         outline_color_ff <= outline_color_in;
         fill_color_ff    <= fill_color_in;
         row_offset_ff    <= row_offset_in;
         octant_x_ff      <= octant_x_in;
         octant_y_ff      <= octant_y_in;
         decision_ff      <= decision_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      r2_ff       <= r2_in;
      y2_ff       <= y2_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.fill_on   = (fill_color_ff[COLOR_W-1:ALPHA_LSB] != '0);
   assign status.fill_last = ($signed(row_offset_ff) >= $signed({1'b0, radius_ff}));
   assign status.y_ge_x    = ($signed(octant_y_ff) >= $signed({1'b0, octant_x_ff}));
   assign status.root_done = root_done;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/crfo_ctrl.sv =====
module crfo_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_restart,
   output logic                       req_tready,
   input  crfo_pkg::crfo_status_type  status,
   output crfo_pkg::crfo_cmd_type     cmd
);
   import crfo_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FILL,
      PH_OSTART,
      PH_OLOOP
   } phase_type;

   typedef enum logic [2:0] {
      S_WAIT,
      S_DISPATCH,
      S_SUB,
      S_ROOT,
      S_SPAN,
      S_OCT,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   oct_type   oct_ff, oct_in;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      oct_in     = oct_ff;
      cmd        = '0;
      cmd.octant = oct_ff;
      req_tready = 1'b0;

      unique case (state_ff)
         S_WAIT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_DISPATCH;
               if (req_restart) begin
                  if (status.fill_on) begin
                     cmd.init_fill = 1'b1;
                     phase_in      = PH_FILL;
                  end else begin
                     cmd.init_outline = 1'b1;
                     phase_in         = PH_OSTART;
                  end
               end
            end
         end
         S_DISPATCH: begin
            unique case (phase_ff)
               PH_IDLE: state_in = S_WAIT;
               PH_FILL: begin
                  cmd.square = 1'b1;
                  state_in   = S_SUB;
               end
               PH_OSTART: begin
                  phase_in = PH_OLOOP;
                  oct_in   = OCT_FIRST;
                  state_in = S_OCT;
               end
               PH_OLOOP: begin
                  if (status.y_ge_x) begin
                     cmd.advance = 1'b1;
                     oct_in      = OCT_FIRST;
                     state_in    = S_OCT;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               default: state_in = S_WAIT;
            endcase
         end
         S_SUB: begin
            cmd.root_load = 1'b1;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            if (status.root_done) begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            if (status.out_free) begin
               cmd.emit_span = 1'b1;
               state_in      = S_WAIT;
               if (status.fill_last) begin
                  cmd.init_outline = 1'b1;
                  phase_in         = PH_OSTART;
               end else begin
                  cmd.row_inc = 1'b1;
               end
            end
         end
         S_OCT: begin
            if (status.out_free) begin
               cmd.emit_pixel = 1'b1;
               oct_in         = oct_ff + OCT_W'(1);
               if (oct_ff == OCT_LAST) begin
                  state_in = S_WAIT;
               end
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.emit_finish = 1'b1;
               phase_in        = PH_IDLE;
               state_in        = S_WAIT;
            end
         end
         default: state_in = S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
         phase_ff <= PH_IDLE;
         oct_ff   <= OCT_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         oct_ff   <= oct_in;
      end
   end

endmodule

// ===== sv/circle_raster_fill_outline.sv =====
// order: an outline step passes dispatch, then the octant state puts its first pixel beat in the
// result register, then one beat per cycle while that register is free; a fill step goes through
// dispatch (square), subtract and the two-bits-a-cycle square root before the span state emits it
// flow: eight pixel beats per outline step from one result register; no new step until the last beat
// reset: synchronous, active high; clears registers and drawing to idle, result register empty
module circle_raster_fill_outline (
   input  logic                              clock,
   input  logic                              reset,

   // step channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [crfo_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart, rest zero

   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crfo_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // x_start, x_end, row, pixel_color, zero pad
   output logic [crfo_pkg::RSP_USER_W-1:0]   rsp_tuser,   // kind[1:0], last_of_drawing
   output logic                              rsp_tlast,   // last_of_step

   // register writes
   input  logic                              csr_we,
   input  crfo_pkg::csr_idx_type             csr_index,
   input  logic [crfo_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import crfo_pkg::*;

   crfo_cmd_type    cmd;
   crfo_status_type status;

   // sequencer: phase of the drawing, octant counter, wait on result register
   crfo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   // registers, midpoint state, squares, square root unit and result register
   crfo_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/circle_raster_fill_outline_test.sv =====
module circle_raster_fill_outline_test;
   timeunit 1ns;
   timeprecision 1ps;

   import crfo_pkg::*;

   // run limits
   localparam int TIMEOUT_CYCLES = 400_000;   // far above the slowest correct run
   localparam int SETTLE_CYCLES  = 40;        // covers a fill step plus pipeline slack
   localparam int HOLD_CYCLES    = 200;       // long receiver hold-off, fills the block
   localparam int RANDOM_STEPS   = 43;        // counted steps per idling phase

   // drawing phases of the predictor
   typedef enum logic [1:0] {
      DRAW_IDLE,
      DRAW_FILL,
      DRAW_RING_START,
      DRAW_RING_LOOP
   } draw_phase_type;

   // one result beat, fields as they leave the block
   typedef struct {
      kind_type           kind;
      logic [OUT_W-1:0]   x_start;
      logic [OUT_W-1:0]   x_end;
      logic [OUT_W-1:0]   row;
      logic [COLOR_W-1:0] color;
      logic               last_step;
      logic               last_drawing;
   } raster_beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block ports, every input driven to a known value from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   csr_idx_type           csr_index  = CSR_CENTER_X;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor copy of the registers
   logic signed [COORD_WIDTH-1:0] ctr_x     = '0;
   logic signed [COORD_WIDTH-1:0] ctr_y     = '0;
   logic [RADIUS_WIDTH-1:0]       rad       = '0;
   logic [COLOR_W-1:0]            ring_rgba = '0;
   logic [COLOR_W-1:0]            fill_rgba = '0;

   // predictor copy of the drawing state
   draw_phase_type draw_phase = DRAW_IDLE;
   int             fill_row   = 0;
   int             ring_x     = 0;
   int             ring_y     = 0;
   int             ring_d     = 0;

   // beats predicted but not yet seen on the result channel
   raster_beat_type pending_beats[$];

   // bookkeeping
   int   mismatches     = 0;
   int   steps_sent     = 0;
   int   cycle_count    = 0;
   int   send_gap_pct   = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold       = 1'b0;

   circle_raster_fill_outline dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [0] restart, rest zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // x_start, x_end, row, pixel_color, zero pad
      .rsp_tuser  (rsp_tuser),    // kind[1:0], last_of_drawing
      .rsp_tlast  (rsp_tlast),    // last_of_step
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // exact floor of the square root, bit by bit from the top
   function automatic int int_sqrt(longint n);
      longint root;
      longint trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root + (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return int'(root);
   endfunction

   // coordinates wrap to the output width
   function automatic void push_beat(kind_type k, int xs, int xe, int yr,
                                     logic [COLOR_W-1:0] c, logic ls, logic ld);
      raster_beat_type b;
      b.kind         = k;
      b.x_start      = xs[OUT_W-1:0];
      b.x_end        = xe[OUT_W-1:0];
      b.row          = yr[OUT_W-1:0];
      b.color        = c;
      b.last_step    = ls;
      b.last_drawing = ld;
      pending_beats.push_back(b);
   endfunction

   // eight mirrored pixels of the current octant point, duplicates kept
   function automatic void push_ring();
      int cx;
      int cy;
      cx = ctr_x;
      cy = ctr_y;
      push_beat(KIND_PIXEL, cx + ring_x, cx + ring_x, cy + ring_y, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx - ring_x, cx - ring_x, cy + ring_y, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx + ring_x, cx + ring_x, cy - ring_y, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx - ring_x, cx - ring_x, cy - ring_y, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx + ring_y, cx + ring_y, cy + ring_x, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx - ring_y, cx - ring_y, cy + ring_x, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx + ring_y, cx + ring_y, cy - ring_x, ring_rgba, 1'b0, 1'b0);
      push_beat(KIND_PIXEL, cx - ring_y, cx - ring_y, cy - ring_x, ring_rgba, 1'b1, 1'b0);
   endfunction

   // midpoint loop starts at the top of the circle
   function automatic void begin_ring();
      ring_x     = 0;
      ring_y     = int'(rad);
      ring_d     = 3 - 2 * int'(rad);
      draw_phase = DRAW_RING_START;
   endfunction

   // one accepted step: advance the drawing and queue the beats it causes
   function automatic void rasterize_step(logic restart);
      longint r_l;
      longint y_l;
      longint rem;
      int     dx;
      int     y;
      if (restart) begin
         if (fill_rgba[COLOR_W-1:ALPHA_LSB] != '0) begin
            fill_row   = -int'(rad);
            draw_phase = DRAW_FILL;
         end else begin
            begin_ring();
         end
      end
      case (draw_phase)
         DRAW_FILL: begin
            // radius is read live, so a shrunk radius can leave rem negative
            y   = fill_row;
            r_l = rad;
            y_l = y;
            rem = r_l * r_l - y_l * y_l;
            dx  = (rem > 0) ? int_sqrt(rem) : 0;
            push_beat(KIND_SPAN, int'(ctr_x) - dx, int'(ctr_x) + dx, int'(ctr_y) + y,
                      fill_rgba, 1'b1, 1'b0);
            if (y >= int'(rad)) begin_ring();
            else fill_row = y + 1;
         end
         DRAW_RING_START: begin
            draw_phase = DRAW_RING_LOOP;
            push_ring();
         end
         DRAW_RING_LOOP: begin
            if (ring_y >= ring_x) begin
               ring_x++;
               if (ring_d > 0) begin
                  ring_y--;
                  ring_d += 4 * (ring_x - ring_y) + 10;
               end else begin
                  ring_d += 4 * ring_x + 6;
               end
               push_ring();
            end else begin
               draw_phase = DRAW_IDLE;
               push_beat(KIND_FINISH, 0, 0, 0, '0, 1'b1, 1'b1);
            end
         end
         default: ;   // advance while idle: nothing comes out
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result channel: ready driver and checker
   // ------------------------------------------------------------------

   // ready changes on the falling edge; a hold-off forces it low
   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // every accepted beat is compared against the oldest prediction
   always @(posedge clock) begin : result_check
      raster_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            flag_mismatch("unexpected beat, kind", rsp_tuser[KIND_W-1:0], 0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tuser[KIND_W-1:0] != want.kind)
               flag_mismatch("kind", rsp_tuser[KIND_W-1:0], want.kind);
            if (rsp_tdata[0 +: OUT_W] != want.x_start)
               flag_mismatch("x_start", rsp_tdata[0 +: OUT_W], want.x_start);
            if (rsp_tdata[OUT_W +: OUT_W] != want.x_end)
               flag_mismatch("x_end", rsp_tdata[OUT_W +: OUT_W], want.x_end);
            if (rsp_tdata[2*OUT_W +: OUT_W] != want.row)
               flag_mismatch("row", rsp_tdata[2*OUT_W +: OUT_W], want.row);
            if (rsp_tdata[3*OUT_W +: COLOR_W] != want.color)
               flag_mismatch("pixel_color", rsp_tdata[3*OUT_W +: COLOR_W], want.color);
            if (rsp_tlast != want.last_step)
               flag_mismatch("last_of_step", rsp_tlast, want.last_step);
            if (rsp_tuser[KIND_W] != want.last_drawing)
               flag_mismatch("last_of_drawing", rsp_tuser[KIND_W], want.last_drawing);
         end
      end
   end

   // hang guard
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // shared stimulus tasks; each starts and ends on a falling edge
   // ------------------------------------------------------------------

   task automatic set_idling(int gap_pct, int stall_pct);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
   endtask

   // offer one step beat, optionally after random gaps, and predict on accept
   task automatic send_step(input logic restart);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
      // advances of an idle block do not count toward the random quota
      if (restart || draw_phase != DRAW_IDLE) steps_sent++;
      rasterize_step(restart);
      @(negedge clock);
   endtask

   // sender stops until every predicted beat is in, then lets the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; only called while the block is quiet
   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_CENTER_X:      ctr_x     = value[COORD_WIDTH-1:0];
         CSR_CENTER_Y:      ctr_y     = value[COORD_WIDTH-1:0];
         CSR_RADIUS:        rad       = value[RADIUS_WIDTH-1:0];
         CSR_OUTLINE_COLOR: ring_rgba = value;
         CSR_FILL_COLOR:    fill_rgba = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_regs(int cx, int cy, int r, logic [31:0] oc, logic [31:0] fc);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_OUTLINE_COLOR, oc);
      write_reg(CSR_FILL_COLOR, fc);
   endtask

   task automatic finish_drawing();
      while (draw_phase != DRAW_IDLE) send_step(1'b0);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // advance while idle gives nothing; reset registers draw a zero-radius ring
   task automatic test_idle_after_reset();
      set_idling(0, 0);
      send_step(1'b0);
      send_step(1'b1);
      finish_drawing();
      drain_and_settle();
   endtask

   // zero radius with fill: one span of width one, then the degenerate ring
   task automatic test_zero_radius_extremes();
      write_regs(-2048, 2047, 0, 32'hFFFF_FFFF, 32'hFF00_0000);
      send_step(1'b1);
      finish_drawing();
      drain_and_settle();
   endtask

   // complete small circle at the opposite corner, coordinates reach past the 12-bit range
   task automatic test_small_full_circle();
      write_regs(2047, -2048, 2, 32'h0000_0000, 32'h01AB_CDEF);
      send_step(1'b1);
      finish_drawing();
      drain_and_settle();
   endtask

   // largest radius: first fill rows at one corner, then the outline start at the other
   task automatic test_largest_radius();
      write_regs(2047, -2048, 1023, 32'h5A5A_A5A5, 32'h8000_0001);
      send_step(1'b1);
      send_step(1'b0);
      drain_and_settle();
      write_reg(CSR_CENTER_X, -2048);
      write_reg(CSR_CENTER_Y, 2047);
      write_reg(CSR_FILL_COLOR, 32'h00FF_FFFF);
      // restart mid-fill with fill now off goes straight to the outline
      send_step(1'b1);
      send_step(1'b0);
      drain_and_settle();
   endtask

   // registers changed between steps of one drawing, then restart mid-outline
   task automatic test_registers_mid_drawing();
      write_regs(0, 0, 3, 32'h00FF_00FF, 32'h7F12_3456);
      send_step(1'b1);
      repeat (4) send_step(1'b0);
      drain_and_settle();
      // radius below the current row: zero half-width and the fill ends
      write_reg(CSR_RADIUS, 1);
      send_step(1'b0);
      drain_and_settle();
      write_reg(CSR_CENTER_X, -5);
      write_reg(CSR_OUTLINE_COLOR, 32'hC0FF_EE00);
      send_step(1'b0);
      send_step(1'b1);
      send_step(1'b0);
      drain_and_settle();
   endtask

   // receiver holds off while steps keep coming, so the block must stall its input
   task automatic test_backpressure();
      set_idling(0, 0);
      write_regs(100, -100, 9, 32'h1234_5678, 32'h00FF_FFFF);
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      send_step(1'b1);
      repeat (9) send_step(1'b0);
      drain_and_settle();
   endtask

   // one random drawing, mostly run to its end, with rare noise; budget caps its steps
   task automatic random_drawing(int budget);
      int          pick;
      int          n;
      int          max_steps;
      int          nx;
      int          ny;
      int          nr;
      logic [31:0] noc;
      logic [31:0] nfc;
      drain_and_settle();
      pick = $urandom_range(99);
      if (pick < 70)      nr = $urandom_range(8);
      else if (pick < 85) nr = $urandom_range(40, 9);
      else if (pick < 93) nr = 1023;
      else                nr = $urandom_range(1023);
      if ($urandom_range(7) == 0) nx = $urandom_range(1) ? 2047 : -2048;
      else                        nx = int'($urandom_range(4095)) - 2048;
      if ($urandom_range(7) == 0) ny = $urandom_range(1) ? 2047 : -2048;
      else                        ny = int'($urandom_range(4095)) - 2048;
      noc = $urandom;
      nfc = $urandom;
      if ($urandom_range(2) == 0) nfc[31:24] = 8'h00;
      write_regs(nx, ny, nr, noc, nfc);
      // big circles are cut short by a later restart
      max_steps = (nr > 40) ? int'($urandom_range(20, 3)) : 400;
      if (max_steps > budget) max_steps = budget;
      send_step(1'b1);
      n = 0;
      while (draw_phase != DRAW_IDLE && n < max_steps) begin
         send_step($urandom_range(99) < 2);
         n++;
         if ($urandom_range(99) < 3) begin
            // register change between two steps of the same drawing
            drain_and_settle();
            case ($urandom_range(4))
               0:       write_reg(CSR_CENTER_X, int'($urandom_range(4095)) - 2048);
               1:       write_reg(CSR_CENTER_Y, int'($urandom_range(4095)) - 2048);
               2:       write_reg(CSR_RADIUS, $urandom_range(40));
               3:       write_reg(CSR_OUTLINE_COLOR, $urandom);
               default: write_reg(CSR_FILL_COLOR, $urandom);
            endcase
         end
      end
      // stray advance, usually on an idle block
      if ($urandom_range(3) == 0) send_step(1'b0);
   endtask

   // random drawings through each idling profile
   task automatic test_random_drawings();
      int target;
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0:       set_idling(0, 0);
            1:       set_idling(57, 0);
            2:       set_idling(0, 57);
            default: set_idling(6, 6);
         endcase
         target = steps_sent + RANDOM_STEPS;
         while (steps_sent < target) random_drawing(target - steps_sent);
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_idle_after_reset();
      test_zero_radius_extremes();
      test_small_full_circle();
      test_largest_radius();
      test_registers_mid_drawing();
      test_backpressure();
      test_random_drawings();
      // wait out every predicted beat plus a quiet stretch for strays
      drain_and_settle();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== circle_raster_fill_outline.f =====
sv/crfo_pkg.sv
sv/crfo_isqrt.sv
sv/crfo_datapath.sv
sv/crfo_ctrl.sv
sv/circle_raster_fill_outline.sv
bench/circle_raster_fill_outline_test.sv
